FILE: rtl/svpwm_pkg.sv
// Shared types and constants for the space vector PWM duty pipeline.
// No dependencies; imported by space_vector_pwm_duty.
`timescale 1ns / 1ps

package svpwm_pkg;

    // Timer counter width; compare values are masked to it.
    localparam int COUNTER_WIDTH = 16;

    localparam int DATA_W  = 16;
    localparam int APB_W   = 32;
    localparam int ADDR_W  = 3;

    // Register indexes (paddr[2])
    localparam logic REG_GAIN   = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    localparam logic [DATA_W-1:0] GAIN_RESET   = 16'd4730;
    localparam logic [DATA_W-1:0] PERIOD_RESET = 16'd3599;

    // sqrt(3) in Q1.16
    localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;

    // Datapath widths
    localparam int VW = 34;               // projections, Q.26 doubled
    localparam int PW = 51;               // gain * projection, Q.43
    localparam int TIME_SHIFT = 13;       // Q.43 -> Q.30
    localparam int XW = 37;               // signed active times
    localparam int TW = 36;               // clamped active times
    localparam int SW = 37;               // t1 + t2, divider remainder
    localparam int TIME_FRAC = 30;
    localparam int QW = TIME_FRAC;        // quotient bits
    localparam int TQ = TIME_FRAC + 1;    // times in 0..1.0
    localparam int MW = DATA_W + TQ;      // period * time

    localparam logic [TQ-1:0] TIME_ONE  = {1'b1, {TIME_FRAC{1'b0}}};
    localparam logic [TQ-1:0] TIME_HALF = TIME_ONE >> 1;

    localparam int DIV_STEPS = QW;

    typedef enum logic [2:0] {
        SECTOR_NONE = 3'd0,
        SECTOR_1    = 3'd1,
        SECTOR_2    = 3'd2,
        SECTOR_3    = 3'd3,
        SECTOR_4    = 3'd4,
        SECTOR_5    = 3'd5,
        SECTOR_6    = 3'd6
    } t_sector;

    // Sign code of the three projections {v3>0, v2>0, v1>0}
    typedef enum logic [2:0] {
        CODE_NULL_LO = 3'd0,
        CODE_S2      = 3'd1,
        CODE_S6      = 3'd2,
        CODE_S1      = 3'd3,
        CODE_S4      = 3'd4,
        CODE_S3      = 3'd5,
        CODE_S5      = 3'd6,
        CODE_NULL_HI = 3'd7
    } t_vcode;

    typedef struct packed {
        logic signed [DATA_W-1:0] ualpha;
        logic signed [DATA_W-1:0] ubeta;
    } t_svpwm_in;

    typedef struct packed {
        logic [DATA_W-1:0] compare_a;
        logic [DATA_W-1:0] compare_b;
        logic [DATA_W-1:0] compare_c;
        logic [2:0]        sector;
        logic              overmodulated;
    } t_svpwm_out;

    // One stage of the twin fractional divider
    typedef struct packed {
        logic          vld;
        t_sector       sector;
        logic          over;
        logic [SW-1:0] sum;
        logic [SW-1:0] r1;
        logic [QW-1:0] q1;
        logic [SW-1:0] r2;
        logic [QW-1:0] q2;
        logic [TQ-1:0] t1;
        logic [TQ-1:0] t2;
    } t_div_stage;

    function automatic t_sector code_to_sector(input t_vcode code);
        t_sector s;
        case (code)
            CODE_S1: s = SECTOR_1;
            CODE_S2: s = SECTOR_2;
            CODE_S3: s = SECTOR_3;
            CODE_S4: s = SECTOR_4;
            CODE_S5: s = SECTOR_5;
            CODE_S6: s = SECTOR_6;
            default: s = SECTOR_NONE;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/space_vector_pwm_duty.sv
// Space vector PWM duty generator: alpha/beta vector to three phase compare values.
// Throughput: one item per cycle; busy stays low. Depth is set by the 30-step divider pipe.
// Reset (synchronous, active low) empties the pipeline and restores
// voltage_gain = 4730, pwm_period = 3599. The result strobe o_done cannot be held off.
`timescale 1ns / 1ps

module space_vector_pwm_duty
    import svpwm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_svpwm_in         i_item,
    output logic              o_done,
    output t_svpwm_out        o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    localparam int LATENCY = DIV_STEPS + 7;
    localparam logic [DATA_W-1:0] CMP_MASK = (COUNTER_WIDTH >= DATA_W) ? {DATA_W{1'b1}}
        : DATA_W'((32'd1 << COUNTER_WIDTH) - 32'd1);

    // ---------------- configuration ----------------
    logic [DATA_W-1:0] r_gain;
    logic [DATA_W-1:0] r_period;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_period <= PERIOD_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_GAIN:   r_gain   <= pwdata[DATA_W-1:0];
                REG_PERIOD: r_period <= pwdata[DATA_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_GAIN:   prdata = APB_W'(r_gain);
            REG_PERIOD: prdata = APB_W'(r_period);
            default:    prdata = '0;
        endcase
    end

    assign busy = 1'b0;

    // ---------------- helpers ----------------
    // Q.43 -> Q.30, rounding half away from zero
    function automatic logic signed [XW-1:0] to_time(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] rnd;
        logic signed [XW-1:0] t;
        mag = p[PW-1] ? (~p + PW'(1)) : p;
        rnd = (mag + (PW'(1) << (TIME_SHIFT - 1))) >> TIME_SHIFT;
        t   = XW'(rnd);
        return p[PW-1] ? -t : t;
    endfunction

    // One restoring step on each of the two quotients
    function automatic t_div_stage div_step(input t_div_stage s);
        t_div_stage o;
        logic [SW:0] rs1;
        logic [SW:0] rs2;
        o   = s;
        rs1 = {s.r1, 1'b0};
        rs2 = {s.r2, 1'b0};
        if (rs1 >= {1'b0, s.sum}) begin
            o.r1 = SW'(rs1 - {1'b0, s.sum});
            o.q1 = {s.q1[QW-2:0], 1'b1};
        end else begin
            o.r1 = SW'(rs1);
            o.q1 = {s.q1[QW-2:0], 1'b0};
        end
        if (rs2 >= {1'b0, s.sum}) begin
            o.r2 = SW'(rs2 - {1'b0, s.sum});
            o.q2 = {s.q2[QW-2:0], 1'b1};
        end else begin
            o.r2 = SW'(rs2);
            o.q2 = {s.q2[QW-2:0], 1'b0};
        end
        return o;
    endfunction

    // ---------------- stage 1: projections ----------------
    logic                 w_accept;
    logic signed [VW-1:0] w_ua;
    logic signed [VW-1:0] w_ub;
    logic signed [VW-1:0] w_ka;
    logic signed [VW-1:0] w_kb;
    logic                 r_s1_vld;
    logic signed [VW-1:0] r_v1, r_v2, r_v3;

    assign w_accept = start & ~busy;
    assign w_ua     = VW'(i_item.ualpha);
    assign w_ub     = VW'(i_item.ubeta);
    assign w_ka     = w_ua * VW'(SQRT3_Q16);
    assign w_kb     = w_ub <<< 16;

    always_ff @(posedge i_clk) begin
        r_v1 <= w_ub <<< 17;
        r_v2 <= w_ka - w_kb;
        r_v3 <= -w_ka - w_kb;
    end

    // ---------------- stage 2: gain products, sector ----------------
    logic signed [PW-1:0] w_gs;
    t_vcode               w_code;
    logic                 r_s2_vld;
    logic signed [PW-1:0] r_p1, r_p2, r_p3;
    t_sector              r_s2_sector;

    assign w_gs   = PW'($signed({1'b0, r_gain}));
    assign w_code = t_vcode'({r_v3 > 0, r_v2 > 0, r_v1 > 0});

    always_ff @(posedge i_clk) begin
        r_p1        <= w_gs * PW'(r_v1);
        r_p2        <= w_gs * PW'(r_v2);
        r_p3        <= w_gs * PW'(r_v3);
        r_s2_sector <= code_to_sector(w_code);
    end

    // ---------------- stage 3: round to times ----------------
    logic                 r_s3_vld;
    logic signed [XW-1:0] r_tx, r_ty, r_tz;
    t_sector              r_s3_sector;

    always_ff @(posedge i_clk) begin
        r_tx        <= to_time(r_p1);
        r_ty        <= -to_time(r_p3);
        r_tz        <= -to_time(r_p2);
        r_s3_sector <= r_s2_sector;
    end

    // ---------------- stage 4: pick active times, check overmodulation ----------------
    logic signed [XW-1:0] w_f, w_s;
    logic [TW-1:0]        w_t1, w_t2;
    logic [SW-1:0]        w_sum;
    t_div_stage           n_s4;
    t_div_stage           r_s4;

    always_comb begin
        case (r_s3_sector)
            SECTOR_2: begin w_f = r_tz;  w_s = r_ty;  end
            SECTOR_6: begin w_f = r_ty;  w_s = -r_tx; end
            SECTOR_1: begin w_f = -r_tz; w_s = r_tx;  end
            SECTOR_4: begin w_f = -r_tx; w_s = r_tz;  end
            SECTOR_3: begin w_f = r_tx;  w_s = -r_ty; end
            SECTOR_5: begin w_f = -r_ty; w_s = -r_tz; end
            default:  begin w_f = '0;    w_s = '0;    end
        endcase
        // a slightly negative time at a sector edge counts as zero
        w_t1  = (w_f > 0) ? TW'(w_f) : '0;
        w_t2  = (w_s > 0) ? TW'(w_s) : '0;
        w_sum = SW'(w_t1) + SW'(w_t2);

        n_s4        = '0;
        n_s4.vld    = r_s3_vld;
        n_s4.sector = r_s3_sector;
        n_s4.over   = w_sum > SW'(TIME_ONE);
        n_s4.sum    = w_sum;
        n_s4.r1     = SW'(w_t1);
        n_s4.r2     = SW'(w_t2);
        n_s4.t1     = TQ'(w_t1);
        n_s4.t2     = TQ'(w_t2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4.vld <= 1'b0;
        end else begin
            r_s4 <= n_s4;
        end
    end

    // ---------------- divider pipe: t * 2^30 / sum ----------------
    t_div_stage r_div [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        t_div_stage w_src;
        if (k == 0) begin : g_first
            assign w_src = r_s4;
        end else begin : g_next
            assign w_src = r_div[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div[k].vld <= 1'b0;
            end else begin
                r_div[k] <= div_step(w_src);
            end
        end
    end

    // ---------------- stage 5: phase times ----------------
    t_div_stage    w_dv;
    logic [TQ-1:0] w_a1, w_a2, w_t0, w_ta, w_tb, w_tc;
    logic          r_s5_vld;
    logic [TQ-1:0] r_ca, r_cb, r_cc;
    t_sector       r_s5_sector;
    logic          r_s5_over;
    logic [TQ-1:0] n_ca, n_cb, n_cc;

    assign w_dv = r_div[DIV_STEPS-1];

    always_comb begin
        w_a1 = w_dv.over ? TQ'(w_dv.q1) : w_dv.t1;
        w_a2 = w_dv.over ? TQ'(w_dv.q2) : w_dv.t2;
        w_t0 = (TIME_ONE - w_a1 - w_a2) >> 1;
        w_ta = w_t0;
        w_tb = w_t0 + w_a1 + w_a2;
        w_tc = w_t0 + w_a2;
        case (w_dv.sector)
            SECTOR_2: begin n_ca = w_tc; n_cb = w_tb; n_cc = w_ta; end
            SECTOR_6: begin n_ca = w_tb; n_cb = w_ta; n_cc = w_tc; end
            SECTOR_1: begin n_ca = w_tb; n_cb = w_tc; n_cc = w_ta; end
            SECTOR_4: begin n_ca = w_ta; n_cb = w_tc; n_cc = w_tb; end
            SECTOR_3: begin n_ca = w_ta; n_cb = w_tb; n_cc = w_tc; end
            SECTOR_5: begin n_ca = w_tc; n_cb = w_ta; n_cc = w_tb; end
            default:  begin n_ca = TIME_HALF; n_cb = TIME_HALF; n_cc = TIME_HALF; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ca        <= n_ca;
        r_cb        <= n_cb;
        r_cc        <= n_cc;
        r_s5_sector <= w_dv.sector;
        r_s5_over   <= w_dv.over && (w_dv.sector != SECTOR_NONE);
    end

    // ---------------- stage 6: scale by period ----------------
    logic          r_s6_vld;
    logic [MW-1:0] r_ma, r_mb, r_mc;
    t_sector       r_s6_sector;
    logic          r_s6_over;

    always_ff @(posedge i_clk) begin
        r_ma        <= MW'(r_period) * MW'(r_ca);
        r_mb        <= MW'(r_period) * MW'(r_cb);
        r_mc        <= MW'(r_period) * MW'(r_cc);
        r_s6_sector <= r_s5_sector;
        r_s6_over   <= r_s5_over;
    end

    // ---------------- stage 7: round, clamp, output register ----------------
    function automatic logic [DATA_W-1:0] to_compare(input logic [MW-1:0] m,
                                                     input logic [DATA_W-1:0] per);
        logic [MW-1:0]   rnd;
        logic [DATA_W:0] c;
        rnd = (m + (MW'(1) << (TIME_FRAC - 1))) >> TIME_FRAC;
        c   = (DATA_W + 1)'(rnd);
        return (c > {1'b0, per}) ? per : c[DATA_W-1:0];
    endfunction

    t_svpwm_out r_result;
    logic       r_done;

    always_ff @(posedge i_clk) begin
        r_result.compare_a     <= to_compare(r_ma, r_period) & CMP_MASK;
        r_result.compare_b     <= to_compare(r_mb, r_period) & CMP_MASK;
        r_result.compare_c     <= to_compare(r_mc, r_period) & CMP_MASK;
        r_result.sector        <= r_s6_sector;
        r_result.overmodulated <= r_s6_over;
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_s1_vld <= w_accept;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s5_vld <= w_dv.vld;
            r_s6_vld <= r_s5_vld;
            r_done   <= r_s6_vld;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

`ifndef ASSERT_OFF
    // every result traces back to an item accepted earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result without matching item");

    // no valid sector: half duty on all phases, never overmodulated
    a_null_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.sector == SECTOR_NONE) |->
        (o_result.compare_a == o_result.compare_b &&
         o_result.compare_b == o_result.compare_c && !o_result.overmodulated))
        else $error("null sector output not at half duty");

    // compare values never exceed the period
    a_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.compare_a <= r_period && o_result.compare_b <= r_period &&
                    o_result.compare_c <= r_period))
        else $error("compare value above period");
`endif

endmodule

FILE: dv/tb_space_vector_pwm_duty.sv
// Self-checking bench for space_vector_pwm_duty: random and directed alpha/beta vectors
// at several gain/period settings, each result checked against a cycle-free duty predictor.
// Depends on svpwm_pkg (rtl/svpwm_pkg.sv) and the space_vector_pwm_duty RTL.
`timescale 1ns / 1ps

module tb_space_vector_pwm_duty
    import svpwm_pkg::*;
();

    localparam int DRAIN_CYCLES = 45;
    localparam int MAX_PRINTS   = 40;

    // Duty predictor and store of expected compare sets
    class duty_scoreboard;
        longint     gain;
        longint     period;
        t_svpwm_out pending_duty[$];
        int         mismatch_count;
        int         checked_count;
        int         overmod_count;

        function new();
            gain   = longint'(GAIN_RESET);
            period = longint'(PERIOD_RESET);
            mismatch_count = 0;
            checked_count  = 0;
            overmod_count  = 0;
        endfunction

        task report_mismatch(string what, longint got, longint want);
            mismatch_count++;
            if (mismatch_count <= MAX_PRINTS)
                $display("[%0t] MISMATCH %s: got %0d want %0d", $realtime, what, got, want);
        endtask

        // gain * projection (Q.43) to Q.30, half away from zero
        function longint gain_time(longint proj);
            longint prod;
            prod = gain * proj;
            if (prod >= 0)
                return (prod + 64'sd4096) >>> 13;
            return -((-prod + 64'sd4096) >>> 13);
        endfunction

        // floor(a * 2^30 / b), a <= b; restoring steps give all ones when a equals b
        function longint fit_fraction(longint a, longint b);
            bit [95:0] num;
            if (a == b)
                return (longint'(1) << TIME_FRAC) - 1;
            num = 96'(a) << TIME_FRAC;
            return longint'(num / 96'(b));
        endfunction

        function logic [DATA_W-1:0] to_count(longint t);
            longint c;
            c = (period * t + (longint'(1) << (TIME_FRAC - 1))) >>> TIME_FRAC;
            if (c > period)
                c = period;
            return c[DATA_W-1:0];
        endfunction

        function t_svpwm_out predict_duty(t_svpwm_in v);
            longint ua, ub, p1, p2, p3, x, y, z, f, s;
            longint t1, t2, t0, ta, tb, tc, ca, cb, cc, total, unit_t;
            t_vcode code;
            t_svpwm_out r;
            unit_t = longint'(TIME_ONE);
            ua = longint'($signed(v.ualpha));
            ub = longint'($signed(v.ubeta));
            p1 = ub * 131072;
            p2 = ua * longint'(SQRT3_Q16) - ub * 65536;
            p3 = -ua * longint'(SQRT3_Q16) - ub * 65536;
            code = t_vcode'({p3 > 0, p2 > 0, p1 > 0});
            x = gain_time(p1);
            y = -gain_time(p3);
            z = -gain_time(p2);
            r = '0;
            f = 0;
            s = 0;
            case (code)
                CODE_S2: begin f = z;  s = y;  r.sector = SECTOR_2; end
                CODE_S6: begin f = y;  s = -x; r.sector = SECTOR_6; end
                CODE_S1: begin f = -z; s = x;  r.sector = SECTOR_1; end
                CODE_S4: begin f = -x; s = z;  r.sector = SECTOR_4; end
                CODE_S3: begin f = x;  s = -y; r.sector = SECTOR_3; end
                CODE_S5: begin f = -y; s = -z; r.sector = SECTOR_5; end
                default: ;
            endcase
            // rounding at a sector edge can leave a tiny negative time
            t1 = (f > 0) ? f : 0;
            t2 = (s > 0) ? s : 0;
            if (t1 + t2 > unit_t) begin
                total = t1 + t2;
                t1 = fit_fraction(t1, total);
                t2 = fit_fraction(t2, total);
                r.overmodulated = 1'b1;
            end
            t0 = (unit_t - t1 - t2) >>> 1;
            ta = t0;
            tb = t0 + t1 + t2;
            tc = t0 + t2;
            case (code)
                CODE_S2: begin ca = tc; cb = tb; cc = ta; end
                CODE_S6: begin ca = tb; cb = ta; cc = tc; end
                CODE_S1: begin ca = tb; cb = tc; cc = ta; end
                CODE_S4: begin ca = ta; cb = tc; cc = tb; end
                CODE_S3: begin ca = ta; cb = tb; cc = tc; end
                CODE_S5: begin ca = tc; cb = ta; cc = tb; end
                default: begin
                    // null vector: half duty everywhere
                    ca = unit_t >>> 1;
                    cb = ca;
                    cc = ca;
                    r.sector = SECTOR_NONE;
                    r.overmodulated = 1'b0;
                end
            endcase
            r.compare_a = to_count(ca);
            r.compare_b = to_count(cb);
            r.compare_c = to_count(cc);
            return r;
        endfunction

        function void note_vector(t_svpwm_in v);
            pending_duty.push_back(predict_duty(v));
        endfunction

        task check_duty(t_svpwm_out got);
            t_svpwm_out want;
            if (pending_duty.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
                return;
            end
            want = pending_duty.pop_front();
            checked_count++;
            if (want.overmodulated)
                overmod_count++;
            if (got.compare_a !== want.compare_a)
                report_mismatch("compare_a", got.compare_a, want.compare_a);
            if (got.compare_b !== want.compare_b)
                report_mismatch("compare_b", got.compare_b, want.compare_b);
            if (got.compare_c !== want.compare_c)
                report_mismatch("compare_c", got.compare_c, want.compare_c);
            if (got.sector !== want.sector)
                report_mismatch("sector", got.sector, want.sector);
            if (got.overmodulated !== want.overmodulated)
                report_mismatch("overmodulated", got.overmodulated, want.overmodulated);
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    t_svpwm_in         i_item = '0;
    logic              o_done;
    t_svpwm_out        o_result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [APB_W-1:0]  pwdata = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    duty_scoreboard sb = new();
    int             idle_pct = 0;
    int             sent_count = 0;
    int             setting_count = 1;

    space_vector_pwm_duty u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_vector(i_item);
            if (o_done)
                sb.check_duty(o_result);
        end
    end

    task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_W-DATA_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_GAIN)
            sb.gain = longint'(value);
        else
            sb.period = longint'(value);
    endtask

    // wait for the pipe to empty, then retune both registers
    task automatic retune(input logic [DATA_W-1:0] gain, input logic [DATA_W-1:0] period);
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_duty.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(REG_GAIN, gain);
        write_reg(REG_PERIOD, period);
        setting_count++;
    endtask

    task automatic send_vector(input logic [DATA_W-1:0] ua, input logic [DATA_W-1:0] ub);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start         <= 1'b1;
        i_item.ualpha <= ua;
        i_item.ubeta  <= ub;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent_count++;
    endtask

    function automatic logic [DATA_W-1:0] extreme_value();
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0001;
            default: return 16'h0000;
        endcase
    endfunction

    task automatic send_random(input int count);
        int          k;
        int          ua;
        int          ub;
        logic [31:0] raw;
        for (k = 0; k < count; k++) begin
            raw = $urandom;
            ua = $signed(raw[31:16]);
            ub = $signed(raw[15:0]);
            case ($urandom_range(9))
                4, 5: begin
                    ua = int'($urandom_range(255)) - 128;
                    ub = int'($urandom_range(255)) - 128;
                end
                6, 7: begin
                    // near a sector edge: beta = 0 or beta = +-sqrt(3) alpha
                    ua = int'($urandom_range(36000)) - 18000;
                    case ($urandom_range(2))
                        0: ub = 0;
                        1: ub = (ua * 113512) >>> 16;
                        default: ub = -((ua * 113512) >>> 16);
                    endcase
                    ub = ub + int'($urandom_range(4)) - 2;
                end
                8: begin
                    ua = $signed(extreme_value());
                    ub = $signed(extreme_value());
                end
                default: ;
            endcase
            send_vector(ua[DATA_W-1:0], ub[DATA_W-1:0]);
        end
    endtask

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", sb.pending_duty.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, extremes, sector centers and edges, null vector
        idle_pct = 0;
        send_vector(16'h0000, 16'h0000);
        send_vector(16'h7FFF, 16'h0000);
        send_vector(16'h8000, 16'h0000);
        send_vector(16'h0000, 16'h7FFF);
        send_vector(16'h0000, 16'h8000);
        send_vector(16'h7FFF, 16'h7FFF);
        send_vector(16'h8000, 16'h8000);
        send_vector(16'h7FFF, 16'h8000);
        send_vector(16'h8000, 16'h7FFF);
        send_vector(16'h0001, 16'h0000);
        send_vector(16'hFFFF, 16'h0000);
        send_vector(16'h0000, 16'h0001);
        send_vector(16'h0000, 16'hFFFF);
        send_vector(16'd887, 16'd512);
        send_vector(16'd0, 16'd1024);
        send_vector(-16'sd887, 16'd512);
        send_vector(-16'sd887, -16'sd512);
        send_vector(16'd0, -16'sd1024);
        send_vector(16'd887, -16'sd512);
        send_vector(16'd591, 16'd1024);
        send_vector(-16'sd591, 16'd1024);
        send_vector(16'd9000, 16'd100);

        retune(16'hFFFF, 16'hFFFF);
        send_random(300);

        retune(16'd1, 16'd1);
        idle_pct = 81;
        send_random(200);

        // zero gain: half duty with a sector still reported
        retune(16'd0, 16'd1000);
        idle_pct = 6;
        send_vector(16'd887, 16'd512);
        send_random(100);

        // zero period: every compare is 0
        retune(16'($urandom_range(1, 65535)), 16'd0);
        idle_pct = 0;
        send_random(100);

        retune(16'd20000, PERIOD_RESET);
        idle_pct = 81;
        send_random(350);

        retune(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        idle_pct = 6;
        send_random(250);

        retune(GAIN_RESET, 16'($urandom_range(1, 65535)));
        idle_pct = 0;
        send_random(200);

        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_duty.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d vectors over %0d gain/period settings, gaps of 0, 6 and 81 percent",
                 sent_count, setting_count);
        $display("%0d results checked, %0d of them overmodulated",
                 sb.checked_count, sb.overmod_count);
        if (sb.mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d field mismatches", sb.mismatch_count);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
